### rtl/core/smm_pkg.sv
package smm_pkg;

  localparam int MAX_SIZE    = 16;
  localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int K_W         = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_C  = 2'd2;

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic done;
  } mac_stat_t;

endpackage

### rtl/core/smm_if.sv
interface smm_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [smm_pkg::CMD_W-1:0]     cmd;
  logic        [smm_pkg::IDX_W-1:0]     row;
  logic        [smm_pkg::IDX_W-1:0]     col;
  logic signed [smm_pkg::DATA_W-1:0]    value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink   (input valid, cmd, row, col, value, output ready);
  modport mon    (input valid, ready, cmd, row, col, value);
endinterface

interface smm_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smm_pkg::DATA_W-1:0]    product;

  modport source (output valid, product, input ready);
  modport sink   (input valid, product, output ready);
  modport mon    (input valid, ready, product);
endinterface

### rtl/core/smm_mac.sv
module smm_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  smm_pkg::mac_ctl_t             ctl,
  input  logic [smm_pkg::DATA_W-1:0]    a,
  input  logic [smm_pkg::DATA_W-1:0]    b,
  output smm_pkg::mac_stat_t            stat,
  output logic [smm_pkg::DATA_W-1:0]    acc
);

  logic [smm_pkg::DATA_W-1:0] prod;
  logic                       prod_valid;
  logic                       prod_last;

  // stage 1: low word of the product, stage 2: wrapping accumulate
  always_ff @(posedge clk) begin
    prod <= smm_pkg::DATA_W'(a * b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      stat.done  <= 1'b0;
    end else begin
      prod_valid <= ctl.valid;
      prod_last  <= ctl.valid & ctl.last;
      stat.done  <= prod_valid & prod_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod;
    end
  end

endmodule

### rtl/core/square_matrix_multiply.sv
// channel | dir | word                          | accepted when
// req     | in  | cmd, row, col, value          | req.valid & req.ready
// rsp     | out | product                       | rsp.valid & rsp.ready
// cfg     | in  | cfg_wdata (matrix_size)       | cfg_we
//
// A read of C[row][col] walks n steps through both element memories (one A and
// one B word per cycle), then passes the memory read registers, the multiply
// and the accumulate before hand-over. A read outside the matrix answers 0.
// Synchronous reset clears control only; element memories are not cleared.
// req.ready stays low while a read is in flight; a waiting rsp word stalls the
// next read only at hand-over.
module square_matrix_multiply (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smm_pkg::SIZE_W-1:0]    cfg_wdata,
  smm_req_if.sink                       req,
  smm_rsp_if.source                     rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [smm_pkg::SIZE_W-1:0]    matrix_size;
  logic [smm_pkg::SIZE_W-1:0]    n_use;
  logic                          in_range;
  logic                          accept;
  logic                          issue;
  logic                          issue_last;
  logic [smm_pkg::K_W-1:0]       k;
  logic [smm_pkg::IDX_W-1:0]     rd_row;
  logic [smm_pkg::IDX_W-1:0]     rd_col;
  logic [smm_pkg::ADDR_W-1:0]    wr_addr;
  logic [smm_pkg::ADDR_W-1:0]    a_addr;
  logic [smm_pkg::ADDR_W-1:0]    b_addr;
  logic [smm_pkg::DATA_W-1:0]    left_mem  [smm_pkg::STORE_DEPTH];
  logic [smm_pkg::DATA_W-1:0]    right_mem [smm_pkg::STORE_DEPTH];
  logic [smm_pkg::DATA_W-1:0]    a_word;
  logic [smm_pkg::DATA_W-1:0]    b_word;
  logic                          word_valid;
  logic                          word_last;
  logic                          handover;
  smm_pkg::mac_ctl_t             mac_ctl;
  smm_pkg::mac_stat_t            mac_stat;
  logic [smm_pkg::DATA_W-1:0]    acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= smm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      matrix_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (matrix_size == '0) begin
      n_use = smm_pkg::SIZE_W'(1);
    end else if (32'(matrix_size) > smm_pkg::MAX_SIZE) begin
      n_use = smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
    end else begin
      n_use = matrix_size;
    end
  end

  assign in_range  = ({1'b0, req.row} < n_use) && ({1'b0, req.col} < n_use);
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid & req.ready;

  assign issue      = (state == ST_RUN);
  assign issue_last = (32'(k) + 1 == 32'(n_use));
  assign handover   = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  assign wr_addr = smm_pkg::ADDR_W'(32'(req.row) * smm_pkg::MAX_SIZE + 32'(req.col));
  assign a_addr  = smm_pkg::ADDR_W'(32'(rd_row) * smm_pkg::MAX_SIZE + 32'(k));
  assign b_addr  = smm_pkg::ADDR_W'(32'(k) * smm_pkg::MAX_SIZE + 32'(rd_col));

  always_ff @(posedge clk) begin
    if (accept && in_range && req.cmd == smm_pkg::CMD_WRITE_A) begin
      left_mem[wr_addr] <= req.value;
    end
    if (issue) begin
      a_word <= left_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range && req.cmd == smm_pkg::CMD_WRITE_B) begin
      right_mem[wr_addr] <= req.value;
    end
    if (issue) begin
      b_word <= right_mem[b_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req.cmd == smm_pkg::CMD_READ_C) begin
          state_next = in_range ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (issue_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (handover) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      word_valid <= 1'b0;
      word_last  <= 1'b0;
    end else begin
      state      <= state_next;
      word_valid <= issue;
      word_last  <= issue & issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= req.row;
      rd_col <= req.col;
      k      <= '0;
    end else if (issue) begin
      k <= k + 1'b1;
    end
  end

  // clearing on every read accept leaves 0 for an out-of-range read
  assign mac_ctl.clear = accept && req.cmd == smm_pkg::CMD_READ_C;
  assign mac_ctl.valid = word_valid;
  assign mac_ctl.last  = word_last;

  smm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (a_word),
    .b    (b_word),
    .stat (mac_stat),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (handover) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handover) begin
      rsp.product <= acc;
    end
  end

endmodule

### rtl/core/smm_check.sv
module smm_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_ready,
  input  logic [smm_pkg::CMD_W-1:0]     req_cmd,
  input  logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  logic [smm_pkg::DATA_W-1:0]    rsp_product
);

  // a read keeps the block busy in the cycle after it is accepted
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_cmd == smm_pkg::CMD_READ_C) |=> !req_ready)
    else $error("request accepted straight after a read");

  // writes and unused codes never raise a word
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_cmd != smm_pkg::CMD_READ_C && !rsp_valid)
      |=> !rsp_valid)
    else $error("word raised without a read");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_product)))
    else $error("stalled response word changed");

endmodule

bind square_matrix_multiply smm_check u_smm_check (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_cmd     (req.cmd),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_product (rsp.product)
);

### tb/tb_square_matrix_multiply.sv
`timescale 1ns / 100ps

module tb_square_matrix_multiply;
  import smm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_WORDS = 50;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    bit                cfg;
    req_word_t         w;
    bit                chk;
    logic [DATA_W-1:0] want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  smm_req_if req_if ();
  smm_rsp_if rsp_if ();

  square_matrix_multiply u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // model state: both matrices, which elements hold a value, the size register
  logic [DATA_W-1:0] mat_a [STORE_DEPTH];
  logic [DATA_W-1:0] mat_b [STORE_DEPTH];
  bit                a_known [STORE_DEPTH];
  bit                b_known [STORE_DEPTH];
  logic [SIZE_W-1:0] cur_size;

  logic [DATA_W-1:0] pending_products [$];
  logic [DATA_W-1:0] want_product;
  int errors;
  int cycles;
  int hold_left;
  bit hold_req;
  bit calm;

  // cfg rows carry the new size in value; chk rows carry a hand-worked product
  plan_row_t plan [22] = '{
    '{1'b0, '{CMD_WRITE_A, 4'd15, 4'd15, 32'h1234_5678}, 1'b0, 32'h0},
    '{1'b1, '{CMD_NONE,    4'd0,  4'd0,  32'd2},         1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_A, 4'd0,  4'd0,  32'hffff_ffff}, 1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_A, 4'd0,  4'd1,  32'h8000_0000}, 1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_B, 4'd0,  4'd0,  32'hffff_ffff}, 1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_B, 4'd1,  4'd0,  32'h0000_0001}, 1'b0, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd0,  4'd0,  32'h0},         1'b1, 32'h8000_0001},
    '{1'b0, '{CMD_WRITE_A, 4'd1,  4'd0,  32'h7fff_ffff}, 1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_A, 4'd1,  4'd1,  32'h0000_0000}, 1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_B, 4'd0,  4'd1,  32'h7fff_ffff}, 1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_B, 4'd1,  4'd1,  32'h7fff_ffff}, 1'b0, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd0,  4'd1,  32'h0},         1'b0, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd1,  4'd0,  32'h0},         1'b0, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd1,  4'd1,  32'h0},         1'b0, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd0,  4'd2,  32'h0},         1'b1, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd15, 4'd15, 32'h0},         1'b1, 32'h0},
    '{1'b0, '{CMD_WRITE_A, 4'd2,  4'd0,  32'd5},         1'b0, 32'h0},
    '{1'b0, '{CMD_NONE,    4'd15, 4'd15, 32'hffff_ffff}, 1'b0, 32'h0},
    '{1'b0, '{CMD_WRITE_B, 4'd15, 4'd15, 32'hffff_ffff}, 1'b0, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd0,  4'd0,  32'h0},         1'b1, 32'h8000_0001},
    '{1'b0, '{CMD_WRITE_A, 4'd0,  4'd0,  32'h0},         1'b0, 32'h0},
    '{1'b0, '{CMD_READ_C,  4'd0,  4'd0,  32'h0},         1'b1, 32'h8000_0000}
  };

  logic [SIZE_W-1:0] phase_sizes [10] = '{
    5'd1, 5'd16, 5'd5, 5'd0, 5'd31, 5'd4, 5'd17, 5'd3, 5'd8, 5'd12
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** square_matrix_multiply: FAILED **");
      $finish;
    end
  end

  function automatic int size_in_force(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIZE) return MAX_SIZE;
    return int'(s);
  endfunction

  function automatic void apply_word(input req_word_t w, output bit has,
                                     output logic [DATA_W-1:0] prod);
    int n;
    bit in_range;
    n = size_in_force(cur_size);
    in_range = (w.row < n) && (w.col < n);
    has = 1'b0;
    prod = '0;
    case (w.cmd)
      CMD_WRITE_A: begin
        if (in_range) begin
          mat_a[w.row * MAX_SIZE + w.col] = w.value;
          a_known[w.row * MAX_SIZE + w.col] = 1'b1;
        end
      end
      CMD_WRITE_B: begin
        if (in_range) begin
          mat_b[w.row * MAX_SIZE + w.col] = w.value;
          b_known[w.row * MAX_SIZE + w.col] = 1'b1;
        end
      end
      CMD_READ_C: begin
        has = 1'b1;
        if (in_range)
          for (int k = 0; k < n; k++)
            prod = prod + mat_a[w.row * MAX_SIZE + k] * mat_b[k * MAX_SIZE + w.col];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(1) ? 32'($urandom_range(15)) : -32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input req_word_t w, input bit use_want,
                           input logic [DATA_W-1:0] want);
    bit has;
    logic [DATA_W-1:0] prod;
    while (!calm && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= w.cmd;
    req_if.row   <= w.row;
    req_if.col   <= w.col;
    req_if.value <= w.value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_word(w, has, prod);
    if (has) pending_products.push_back(use_want ? want : prod);
  endtask

  // only change the size once the block has gone quiet
  task automatic set_size(input logic [SIZE_W-1:0] s);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_size = s;
  endtask

  // a product read must only touch elements that hold a value
  task automatic fill_for_read(input int r, input int c, input int n);
    for (int k = 0; k < n; k++) begin
      if (!a_known[r * MAX_SIZE + k])
        send_word(req_word_t'{CMD_WRITE_A, IDX_W'(r), IDX_W'(k), pick_value()},
                  1'b0, '0);
      if (!b_known[k * MAX_SIZE + c])
        send_word(req_word_t'{CMD_WRITE_B, IDX_W'(k), IDX_W'(c), pick_value()},
                  1'b0, '0);
    end
  endtask

  task automatic random_word();
    int n;
    int pick;
    req_word_t w;
    n = size_in_force(cur_size);
    pick = $urandom_range(99);
    w.value = pick_value();
    w.row = IDX_W'($urandom_range(n - 1));
    w.col = IDX_W'($urandom_range(n - 1));
    if (pick < 45) begin
      w.cmd = CMD_READ_C;
      fill_for_read(int'(w.row), int'(w.col), n);
    end else if (pick < 75) begin
      w.cmd = $urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A;
    end else if (pick < 93) begin
      // outside the matrix where the size leaves room for it
      if (pick < 84) w.cmd = CMD_READ_C;
      else w.cmd = $urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A;
      if (n < MAX_SIZE) begin
        if ($urandom_range(1)) begin
          w.row = IDX_W'($urandom_range(MAX_SIZE - 1, n));
          w.col = IDX_W'($urandom_range(MAX_SIZE - 1));
        end else begin
          w.col = IDX_W'($urandom_range(MAX_SIZE - 1, n));
          w.row = IDX_W'($urandom_range(MAX_SIZE - 1));
        end
      end else if (w.cmd == CMD_READ_C) begin
        fill_for_read(int'(w.row), int'(w.col), n);
      end
    end else begin
      w.cmd = CMD_NONE;
      w.row = IDX_W'($urandom);
      w.col = IDX_W'($urandom);
    end
    send_word(w, 1'b0, '0);
  endtask

  // result side: random back-pressure, one long hold on request, checking
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_products.size() == 0) begin
          $error("product: no word expected, got %h", rsp_if.product);
          errors++;
        end else begin
          want_product = pending_products.pop_front();
          if (rsp_if.product !== want_product) begin
            $error("product: expected %h, got %h", want_product, rsp_if.product);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    req_if.valid <= 1'b0;
    req_if.cmd   <= CMD_NONE;
    req_if.row   <= '0;
    req_if.col   <= '0;
    req_if.value <= '0;
    errors = 0;
    cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    cur_size = SIZE_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) set_size(plan[i].w.value[SIZE_W-1:0]);
      else send_word(plan[i].w, plan[i].chk, plan[i].want);
    end

    foreach (phase_sizes[p]) begin
      set_size(phase_sizes[p]);
      calm = (p == 2);
      if (p == 5) hold_req = 1'b1;
      repeat (PHASE_WORDS) random_word();
    end
    calm = 1'b0;

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("** square_matrix_multiply: PASSED **");
    else
      $display("** square_matrix_multiply: FAILED **");
    $finish;
  end

endmodule

### square_matrix_multiply.f
rtl/core/smm_pkg.sv
rtl/core/smm_if.sv
rtl/core/smm_mac.sv
rtl/core/square_matrix_multiply.sv
rtl/core/smm_check.sv
tb/tb_square_matrix_multiply.sv
